>>> hw/rtl/cnht_pkg.sv
// ----------------------------------------------------------------------------
// cnht_pkg: shared types and constants for the chained name hash table
// Sizes, action and status codes, and the records passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package cnht_pkg;

  // table geometry
  localparam int BUCKETS     = 1024;
  localparam int MAX_ENTRIES = 4096;
  localparam int BUCKET_W    = $clog2(BUCKETS);
  localparam int INDEX_W     = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = INDEX_W + 1;

  // field widths on the ports
  localparam int WORD_W        = 32;
  localparam int NAME_W        = 2 * WORD_W;
  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_INDEX_W = 12;
  localparam int M_TDATA_W     = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [WORD_W-1:0] HASH_MULT = 32'd1315423911;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // one classified item on its way to the back part
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NAME_W-1:0]   key;
    logic [BUCKET_W-1:0] bucket;
  } work_t;

  // chain pointer with its valid bit
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
  } link_t;

  // one stored entry: link to the older entry and the name
  typedef struct packed {
    link_t             link;
    logic [NAME_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/cnht_front.sv
// ----------------------------------------------------------------------------
// cnht_front: input stage of the name hash table
// Takes a transfer, cleans the name, folds case for lookups, hashes the
// name to its bucket and pushes the result into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cnht_front (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            enable,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [cnht_pkg::ACTION_W-1:0]  s_tuser,  // action
  input  wire  [cnht_pkg::NAME_W-1:0]    s_tdata,  // name_low_word, name_high_word
  output logic                           q_push,
  output cnht_pkg::work_t                q_item,
  input  wire                            q_full
);

  logic                          stage_valid;
  logic [cnht_pkg::ACTION_W-1:0] stage_action;
  logic [cnht_pkg::NAME_W-1:0]   stage_key;
  logic [cnht_pkg::NAME_W-1:0]   clean_name;
  logic [cnht_pkg::WORD_W-1:0]   mix;
  logic [cnht_pkg::WORD_W-1:0]   hashed;

  // clear every byte after the first zero byte
  function automatic logic [cnht_pkg::NAME_W-1:0] zero_after_nul(
    input logic [cnht_pkg::NAME_W-1:0] name
  );
    logic [cnht_pkg::NAME_W-1:0] res;
    logic                        hit;
    res = '0;
    hit = 1'b0;
    for (int i = 0; i < cnht_pkg::NAME_W / 8; i++) begin
      if (name[8*i +: 8] == 8'h00) hit = 1'b1;
      if (!hit) res[8*i +: 8] = name[8*i +: 8];
    end
    return res;
  endfunction

  // a-z to upper case, other bytes untouched
  function automatic logic [cnht_pkg::NAME_W-1:0] fold_upper(
    input logic [cnht_pkg::NAME_W-1:0] name
  );
    logic [cnht_pkg::NAME_W-1:0] res;
    res = name;
    for (int i = 0; i < cnht_pkg::NAME_W / 8; i++) begin
      if (name[8*i +: 8] >= 8'h61 && name[8*i +: 8] <= 8'h7a) begin
        res[8*i +: 8] = name[8*i +: 8] - 8'h20;
      end
    end
    return res;
  endfunction

  // stage advances, once enabled, when empty or when the queue takes its item
  assign s_tready   = enable && (!stage_valid || !q_full);
  assign clean_name = zero_after_nul(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_action <= s_tuser;
      stage_key    <= (s_tuser == cnht_pkg::ACT_LOOKUP) ? fold_upper(clean_name)
                                                        : clean_name;
    end
  end

  // bucket hash: low word times the constant, xor high word
  assign mix    = cnht_pkg::WORD_W'(stage_key[cnht_pkg::WORD_W-1:0] * cnht_pkg::HASH_MULT);
  assign hashed = mix ^ stage_key[cnht_pkg::NAME_W-1:cnht_pkg::WORD_W];

  // push into the work queue
  assign q_push        = stage_valid && !q_full;
  assign q_item.action = stage_action;
  assign q_item.key    = stage_key;
  assign q_item.bucket = hashed[cnht_pkg::BUCKET_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/cnht_fifo.sv
// ----------------------------------------------------------------------------
// cnht_fifo: work queue between front and back
// Small register queue of classified items with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module cnht_fifo (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  cnht_pkg::work_t  push_item,
  output logic             full,
  input  wire              pop,
  output cnht_pkg::work_t  pop_item,
  output logic             not_empty
);

  cnht_pkg::work_t             slots [cnht_pkg::QUEUE_DEPTH];
  logic [cnht_pkg::QPTR_W-1:0] wr_ptr;
  logic [cnht_pkg::QPTR_W-1:0] rd_ptr;
  logic [cnht_pkg::QPTR_W:0]   fill;

  assign full      = (fill == (cnht_pkg::QPTR_W+1)'(cnht_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

>>> hw/rtl/cnht_back.sv
// ----------------------------------------------------------------------------
// cnht_back: table engine of the name hash table
// Owns the bucket heads and the entry store, runs clear sweeps, inserts
// and chain walks, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cnht_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 q_valid,
  input  cnht_pkg::work_t                     q_item,
  output logic                                q_pop,
  output logic                                init_done,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [cnht_pkg::STATUS_W-1:0]       m_tuser,  // status
  output logic [cnht_pkg::M_TDATA_W-1:0]      m_tdata   // entry_index, zero fill
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_INS_WR,
    S_LK_HEAD,
    S_LK_ENT
  } state_t;

  state_t                               state;
  logic [cnht_pkg::BUCKET_W-1:0]        sweep_addr;
  logic [cnht_pkg::COUNT_W-1:0]         entry_count;
  cnht_pkg::work_t                      held;
  logic [cnht_pkg::INDEX_W-1:0]         cur_idx;
  logic [cnht_pkg::STATUS_W-1:0]        out_status;
  logic [cnht_pkg::ENTRY_INDEX_W-1:0]   out_index;

  // memories and their ports
  cnht_pkg::link_t                head_mem [cnht_pkg::BUCKETS];
  cnht_pkg::entry_t               ent_mem  [cnht_pkg::MAX_ENTRIES];
  cnht_pkg::link_t                head_rd;
  cnht_pkg::entry_t               ent_rd;
  logic                           head_we;
  logic [cnht_pkg::BUCKET_W-1:0]  head_waddr;
  cnht_pkg::link_t                head_wdata;
  logic                           ent_we;
  logic [cnht_pkg::INDEX_W-1:0]   ent_raddr;
  cnht_pkg::entry_t               ent_wdata;

  logic out_free;
  logic table_full;
  logic ent_hit;

  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (entry_count >= cnht_pkg::COUNT_W'(cnht_pkg::MAX_ENTRIES));
  assign ent_hit    = (ent_rd.key == held.key);
  assign q_pop      = (state == S_IDLE) && init_done && q_valid && out_free;

  // memory port control
  always_comb begin
    head_we          = (state == S_SWEEP) || (state == S_INS_WR);
    head_waddr       = (state == S_SWEEP) ? sweep_addr : held.bucket;
    head_wdata.valid = (state != S_SWEEP);
    head_wdata.idx   = entry_count[cnht_pkg::INDEX_W-1:0];
    ent_we           = (state == S_INS_WR);
    ent_wdata.link   = head_rd;
    ent_wdata.key    = held.key;
    ent_raddr        = (state == S_LK_HEAD) ? head_rd.idx : ent_rd.link.idx;
  end

  // bucket head memory, read at the queue head bucket
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd <= head_mem[q_item.bucket];
  end

  // entry memory, written at the fill count
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[entry_count[cnht_pkg::INDEX_W-1:0]] <= ent_wdata;
    ent_rd <= ent_mem[ent_raddr];
  end

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      entry_count <= '0;
      init_done   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == '1) begin
            state     <= S_IDLE;
            init_done <= 1'b1;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            held <= q_item;
            case (q_item.action)
              cnht_pkg::ACT_CLEAR: begin
                entry_count <= '0;
                state       <= S_SWEEP;
                m_tvalid    <= 1'b1;
                out_status  <= cnht_pkg::ST_OK;
                out_index   <= '0;
              end
              cnht_pkg::ACT_INSERT: begin
                if (table_full) begin
                  m_tvalid   <= 1'b1;
                  out_status <= cnht_pkg::ST_FULL;
                  out_index  <= '0;
                end else begin
                  state <= S_INS_WR;
                end
              end
              cnht_pkg::ACT_LOOKUP: begin
                state <= S_LK_HEAD;
              end
              default: begin
                m_tvalid   <= 1'b1;
                out_status <= cnht_pkg::ST_OK;
                out_index  <= '0;
              end
            endcase
          end
        end
        S_INS_WR: begin
          entry_count <= entry_count + 1'b1;
          m_tvalid    <= 1'b1;
          out_status  <= cnht_pkg::ST_OK;
          out_index   <= cnht_pkg::ENTRY_INDEX_W'(entry_count[cnht_pkg::INDEX_W-1:0]);
          state       <= S_IDLE;
        end
        S_LK_HEAD: begin
          if (head_rd.valid) begin
            cur_idx <= head_rd.idx;
            state   <= S_LK_ENT;
          end else begin
            m_tvalid   <= 1'b1;
            out_status <= cnht_pkg::ST_NOT_FOUND;
            out_index  <= '0;
            state      <= S_IDLE;
          end
        end
        S_LK_ENT: begin
          if (ent_hit) begin
            m_tvalid   <= 1'b1;
            out_status <= cnht_pkg::ST_OK;
            out_index  <= cnht_pkg::ENTRY_INDEX_W'(cur_idx);
            state      <= S_IDLE;
          end else if (ent_rd.link.valid) begin
            cur_idx <= ent_rd.link.idx;
          end else begin
            m_tvalid   <= 1'b1;
            out_status <= cnht_pkg::ST_NOT_FOUND;
            out_index  <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(cnht_pkg::M_TDATA_W - cnht_pkg::ENTRY_INDEX_W){1'b0}}, out_index};

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cnht_pkg::COUNT_W'(cnht_pkg::MAX_ENTRIES))
    else $error("entry count above table size");

  // an insert write always advances the fill count by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("insert did not advance entry count");

  // nothing leaves the queue before the reset sweep ends
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !q_pop)
    else $error("queue popped during reset sweep");

  // a chain walk only runs for a lookup
  a_walk_is_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == S_LK_ENT || state == S_LK_HEAD) |-> (held.action == cnht_pkg::ACT_LOOKUP))
    else $error("chain walk without lookup");

  // a pending table full answer implies a full table
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == cnht_pkg::ST_FULL) |-> table_full)
    else $error("full status with room left");

endmodule

`default_nettype wire

>>> hw/rtl/chained_name_hash_table.sv
// Path: front stage register, work queue, back engine, result register; a lookup
//   also reads the bucket head and one entry memory word per chain link.
// Throughput: one item per cycle for full and unused actions while the result
//   register is free; an insert or a lookup holds the back engine until answered.
// A clear also sweeps the 1024 bucket heads, one per cycle, before the next item.
// Reset: a sweep empties the 1024 buckets; s_tready stays low until done.
// ----------------------------------------------------------------------------
// chained_name_hash_table: directory of 8-byte names with a chained hash
// Front cleans and hashes names, a short queue decouples it from the back
// engine that stores entries and walks bucket chains.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_name_hash_table (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [cnht_pkg::ACTION_W-1:0]      s_tuser,  // action
  input  wire  [cnht_pkg::NAME_W-1:0]        s_tdata,  // name_low_word, name_high_word
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [cnht_pkg::STATUS_W-1:0]      m_tuser,  // status
  output logic [cnht_pkg::M_TDATA_W-1:0]     m_tdata   // entry_index, zero fill
);

  cnht_pkg::work_t push_item;
  cnht_pkg::work_t pop_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;
  logic            init_done;

  // classify and hash
  cnht_front u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (init_done),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_push   (push),
    .q_item   (push_item),
    .q_full   (full)
  );

  // work queue
  cnht_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  // table engine
  cnht_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .init_done (init_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the chained name hash table
// Sends clear, insert, lookup and unused actions over the input stream, keeps
// its own copy of the directory to work out each answer, and compares every
// result transfer with the oldest answer still due.
// ----------------------------------------------------------------------------

module tb;
  import cnht_pkg::*;

  // action code the block ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_ITEMS = 1750;
  localparam int RECENT_MAX   = 300;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_INDEX_W-1:0] index;
  } answer_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ACTION_W-1:0]  s_tuser  = '0;
  logic [NAME_W-1:0]    s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [STATUS_W-1:0]  m_tuser;
  logic [M_TDATA_W-1:0] m_tdata;

  // mirror of the directory
  logic               head_live  [BUCKETS];
  logic [INDEX_W-1:0] head_idx   [BUCKETS];
  logic               link_live  [MAX_ENTRIES];
  logic [INDEX_W-1:0] link_idx   [MAX_ENTRIES];
  logic [NAME_W-1:0]  name_store [MAX_ENTRIES];
  int unsigned        stored_count = 0;

  answer_t           pending_answers[$];
  logic [NAME_W-1:0] recent_names[$];
  int unsigned       error_count   = 0;
  bit                tx_gaps_on    = 1'b1;
  bit                rx_stalls_on  = 1'b1;
  int unsigned       hold_asked    = 0;
  int unsigned       hold_taken    = 0;
  int unsigned       rx_stall_left = 0;

  chained_name_hash_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- names

  // bytes after the first nul read as zero
  function automatic logic [NAME_W-1:0] zero_after_nul(input logic [NAME_W-1:0] nm);
    logic [NAME_W-1:0] out;
    bit                seen;
    out  = '0;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] == 8'h00) seen = 1'b1;
      if (!seen) out[8*i +: 8] = nm[8*i +: 8];
    end
    return out;
  endfunction

  // a-z to A-Z, everything else kept
  function automatic logic [NAME_W-1:0] fold_upper(input logic [NAME_W-1:0] nm);
    logic [NAME_W-1:0] out;
    logic [7:0]        b;
    out = '0;
    for (int i = 0; i < 8; i++) begin
      b = nm[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7a) b = b - 8'h20;
      out[8*i +: 8] = b;
    end
    return out;
  endfunction

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [NAME_W-1:0] nm);
    logic [WORD_W-1:0] mixed;
    mixed = (nm[WORD_W-1:0] * HASH_MULT) ^ nm[NAME_W-1:WORD_W];
    return mixed[BUCKET_W-1:0];
  endfunction

  // byte 0 of the text lands in bits 7:0
  function automatic logic [NAME_W-1:0] text_name(input string s);
    logic [NAME_W-1:0] nm;
    nm = '0;
    for (int i = 0; i < s.len() && i < 8; i++) nm[8*i +: 8] = s[i];
    return nm;
  endfunction

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] nm;
    int unsigned       kind;
    int unsigned       len;
    int unsigned       c;
    nm   = '0;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 8);
    if (kind < 4) begin
      // upper case letters and digits
      for (int i = 0; i < len; i++) begin
        c = $urandom_range(0, 35);
        nm[8*i +: 8] = (c < 26) ? 8'(8'h41 + c) : 8'(8'h30 + c - 26);
      end
    end else if (kind < 6) begin
      // mixed case letters
      for (int i = 0; i < len; i++) begin
        c = $urandom_range(0, 51);
        nm[8*i +: 8] = (c < 26) ? 8'(8'h41 + c) : 8'(8'h61 + c - 26);
      end
    end else begin
      // raw bytes, sometimes with a nul and garbage behind it
      nm = {$urandom, $urandom};
      if (kind >= 8 && len < 8) nm[8*len +: 8] = 8'h00;
    end
    return nm;
  endfunction

  // same name as seen by a lookup: random case, maybe garbage after the nul
  function automatic logic [NAME_W-1:0] vary_name(input logic [NAME_W-1:0] nm);
    logic [NAME_W-1:0] out;
    bit                trail;
    out   = nm;
    trail = 1'($urandom_range(0, 1));
    for (int i = 0; i < 8; i++) begin
      if (out[8*i +: 8] == 8'h00) begin
        if (trail) begin
          for (int j = i + 1; j < 8; j++) out[8*j +: 8] = 8'($urandom);
        end
        break;
      end
      if (out[8*i +: 8] >= 8'h41 && out[8*i +: 8] <= 8'h5a && $urandom_range(0, 1) == 1)
        out[8*i +: 8] = out[8*i +: 8] + 8'h20;
    end
    return out;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ------------------------------------------------------------ predictor

  // apply one action to the mirror and return the answer it gives
  function automatic answer_t predict_directory(input logic [ACTION_W-1:0] act,
                                                input logic [NAME_W-1:0]   raw);
    answer_t             ans;
    logic [NAME_W-1:0]   nm;
    logic [NAME_W-1:0]   key;
    logic [BUCKET_W-1:0] b;
    logic                live;
    logic [INDEX_W-1:0]  cur;
    int unsigned         hops;
    ans.status = ST_OK;
    ans.index  = '0;
    nm = zero_after_nul(raw);
    case (act)
      ACT_CLEAR: begin
        foreach (head_live[i]) head_live[i] = 1'b0;
        stored_count = 0;
      end
      ACT_INSERT: begin
        if (stored_count >= MAX_ENTRIES) begin
          ans.status = ST_FULL;
        end else begin
          b   = bucket_of(nm);
          cur = INDEX_W'(stored_count);
          name_store[cur] = nm;
          link_live[cur]  = head_live[b];
          link_idx[cur]   = head_idx[b];
          head_live[b]    = 1'b1;
          head_idx[b]     = cur;
          stored_count++;
          ans.index = cur;
        end
      end
      ACT_LOOKUP: begin
        key  = fold_upper(nm);
        b    = bucket_of(key);
        live = head_live[b];
        cur  = head_idx[b];
        hops = 0;
        ans.status = ST_NOT_FOUND;
        // newest to oldest along the chain
        while (live && hops <= MAX_ENTRIES) begin
          if (name_store[cur] == key) begin
            ans.status = ST_OK;
            ans.index  = cur;
            break;
          end
          live = link_live[cur];
          cur  = link_idx[cur];
          hops++;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------- input side

  // one transfer; valid is left high so a following item can go back to back
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [NAME_W-1:0] nm);
    int unsigned gap;
    answer_t     ans;
    gap = tx_gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= nm;
    do @(posedge clk); while (s_tready !== 1'b1);
    ans = predict_directory(act, nm);
    pending_answers.push_back(ans);
    if (act == ACT_INSERT && ans.status == ST_OK) begin
      recent_names.push_back(zero_after_nul(nm));
      if (recent_names.size() > RECENT_MAX) void'(recent_names.pop_front());
    end
  endtask

  // lower valid and wait until every answer has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic send_random_item(input bit allow_clear);
    int unsigned       r;
    logic [NAME_W-1:0] nm;
    r = $urandom_range(0, 999);
    if (allow_clear && r < 8) begin
      send_item(ACT_CLEAR, random_name());
    end else if (r < 25) begin
      send_item(ACT_UNUSED, random_name());
    end else if (r < 500) begin
      // some inserts repeat a known name so the newest copy must win
      if (recent_names.size() != 0 && $urandom_range(0, 6) == 0)
        nm = recent_names[$urandom_range(0, recent_names.size() - 1)];
      else
        nm = random_name();
      send_item(ACT_INSERT, nm);
    end else begin
      // mostly names that were stored, seen through case and nul changes
      if (recent_names.size() != 0 && $urandom_range(0, 99) < 65)
        nm = vary_name(recent_names[$urandom_range(0, recent_names.size() - 1)]);
      else
        nm = random_name();
      send_item(ACT_LOOKUP, nm);
    end
  endtask

  // ---------------------------------------------------------- result side

  task automatic check_answer();
    answer_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: result transfer with nothing due, status %0d, entry_index %0d",
               $time, m_tuser, m_tdata);
      error_count++;
    end else begin
      want = pending_answers.pop_front();
      if (m_tuser !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, m_tuser);
        error_count++;
      end
      if (m_tdata !== M_TDATA_W'(want.index)) begin
        $display("%0t: entry_index mismatch, expected %0d, actual %0d",
                 $time, want.index, m_tdata);
        error_count++;
      end
    end
  endtask

  // check each result transfer and pick the ready level for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) check_answer();
    if (hold_asked != hold_taken) begin
      hold_taken    = hold_asked;
      rx_stall_left = HOLD_CYCLES;
    end else if (rx_stall_left == 0 && rx_stalls_on) begin
      rx_stall_left = idle_length();
    end
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ----------------------------------------------------------------- tests

  // empty table, case folding on lookup, newest duplicate wins
  task automatic test_insert_lookup();
    send_item(ACT_LOOKUP, text_name("ABC"));
    send_item(ACT_INSERT, text_name("ABC"));
    send_item(ACT_LOOKUP, text_name("abc"));
    send_item(ACT_INSERT, text_name("abc"));
    send_item(ACT_LOOKUP, text_name("abc"));
    send_item(ACT_INSERT, text_name("ABC"));
    send_item(ACT_LOOKUP, text_name("Abc"));
  endtask

  // garbage after the nul, fold boundaries, all-ones and all-zero names
  task automatic test_case_and_nul();
    send_item(ACT_INSERT, 64'hDEAD_BEEF_5A00_4241);
    send_item(ACT_LOOKUP, 64'h0123_4567_8900_6261);
    // bytes just outside a-z and A-Z are never folded
    send_item(ACT_INSERT, 64'h0000_0000_5B40_7B60);
    send_item(ACT_LOOKUP, 64'h0000_0000_5B40_7B60);
    send_item(ACT_INSERT, text_name("AZ"));
    send_item(ACT_LOOKUP, text_name("az"));
    send_item(ACT_INSERT, '1);
    send_item(ACT_LOOKUP, '1);
    send_item(ACT_INSERT, '0);
    send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00);
  endtask

  // ignored action code, then clear and start over from index zero
  task automatic test_unused_and_clear();
    send_item(ACT_UNUSED, random_name());
    send_item(ACT_UNUSED, '1);
    send_item(ACT_CLEAR, 64'h5555_AAAA_5555_AAAA);
    send_item(ACT_LOOKUP, text_name("ABC"));
    send_item(ACT_INSERT, text_name("ABC"));
    send_item(ACT_LOOKUP, text_name("abc"));
    wait_for_results();
  endtask

  // long receiver hold while items keep coming, then a full drain
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_stalls_on <= 1'b0;
    hold_asked   <= hold_asked + 1;
    repeat (24) send_random_item(1'b0);
    wait_for_results();
    tx_gaps_on = 1'b1;
  endtask

  // random mix, every third stretch without gaps on either side
  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) begin
        tx_gaps_on = ((n / 250) % 3 != 2);
        rx_stalls_on <= ((n / 250) % 3 != 2);
      end
      send_random_item(1'b1);
    end
    wait_for_results();
    tx_gaps_on = 1'b1;
    rx_stalls_on <= 1'b1;
  endtask

  // fill every entry, insert past the end, look names up, then clear and insert again
  task automatic test_full_table();
    send_item(ACT_CLEAR, '0);
    repeat (MAX_ENTRIES) send_item(ACT_INSERT, random_name());
    repeat (3) send_item(ACT_INSERT, random_name());
    repeat (20) send_item(ACT_LOOKUP,
                          vary_name(recent_names[$urandom_range(0, recent_names.size() - 1)]));
    send_item(ACT_LOOKUP, recent_names[$]);
    send_item(ACT_CLEAR, random_name());
    send_item(ACT_LOOKUP, recent_names[$]);
    send_item(ACT_INSERT, recent_names[$]);
    wait_for_results();
  endtask

  // ------------------------------------------------------------- sequence

  initial begin
    foreach (head_live[i]) head_live[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_insert_lookup();
    test_case_and_nul();
    test_unused_and_clear();
    test_backpressure();
    test_random_traffic();
    test_full_table();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
